/* rtl/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the scanline callback scheduler: request and
// response payloads, action codes, table entry layout and default sizes.
// ----------------------------------------------------------------------------
package scs_pkg;

    // Default table depth and last visible scanline
    localparam int unsigned MAX_ENTRIES_DEF = 8;
    localparam int unsigned LAST_LINE_DEF   = 227;

    // Action codes carried in the request
    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_REMOVE  = 3'd1;
    localparam logic [2:0] ACT_CLEAR   = 3'd2;
    localparam logic [2:0] ACT_ENABLE  = 3'd3;
    localparam logic [2:0] ACT_DISABLE = 3'd4;
    localparam logic [2:0] ACT_EVENT   = 3'd5;

    // Request payload
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] entry_tag;
        logic [7:0] start_line;
        logic [7:0] end_line;
        logic [7:0] line;
    } req_t;

    // Response payload
    typedef struct packed {
        logic       fire;
        logic [7:0] fire_tag;
        logic [7:0] compare_line;
        logic [3:0] entry_count;
        logic       rejected;
    } rsp_t;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] first_line;
        logic [7:0] last_line;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* rtl/scs_ram.sv */
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scanline_callback_scheduler.sv */
// ----------------------------------------------------------------------------
// scanline_callback_scheduler
// Table of tagged scanline ranges walked on line-compare events.
// ----------------------------------------------------------------------------
// The table lives in one entry RAM (tag, first line, last line) with a
// registered read; count, current entry, enable and compare line are flops.
// Each request transaction yields exactly one response transaction. Clear,
// disable, add and unused actions read no entry, enable reads the first
// entry, a compare event makes one RAM read for the current entry and one
// more when it moves to the next entry. A remove scans the table one entry
// per cycle up to the match and then shifts the later entries down one per
// cycle. A stalled output holds the block in its done state until the
// output register is free. A new request is taken while the previous
// response still waits in the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module scanline_callback_scheduler #(
    parameter int unsigned MAX_ENTRIES = scs_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned LAST_LINE   = scs_pkg::LAST_LINE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  scs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output scs_pkg::rsp_t rsp
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [7:0] LAST_L = 8'(LAST_LINE);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_LOOKUP = 6'b001000,
        S_NEXT   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    scs_pkg::req_t   item_reg, item_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             enabled_reg, enabled_next;
    logic [7:0]       cmp_reg, cmp_next;
    logic             fire_reg, fire_next;
    logic [7:0]       fire_tag_reg, fire_tag_next;
    logic             rej_reg, rej_next;
    logic             rsp_valid_reg, rsp_valid_next;
    scs_pkg::rsp_t    rsp_reg, rsp_next;

    // Entry RAM port signals
    logic                        ram_we, ram_re;
    logic [IDX_W-1:0]            ram_waddr, ram_raddr;
    scs_pkg::entry_t             ram_wdata, ram_rdata;
    logic [scs_pkg::ENTRY_W-1:0] ram_rdata_raw;

    scs_ram #(
        .WIDTH (scs_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = scs_pkg::entry_t'(ram_rdata_raw);

    // Helper arithmetic on indexes and lines
    logic [CNT_W:0]   idx_p1, idx_p2;
    logic [IDX_W-1:0] cur_eff;
    logic [7:0]       add_first, add_last;

    assign idx_p1  = (CNT_W+1)'(idx_reg) + 1'b1;
    assign idx_p2  = (CNT_W+1)'(idx_reg) + 2'd2;
    assign cur_eff = ((CNT_W+1)'(cur_reg) >= (CNT_W+1)'(count_reg)) ? '0 : cur_reg;

    // Clamp the add range to the last line; a bad end takes the start
    always_comb
    begin
        logic [7:0] e;
        e = ((req.end_line < req.start_line) || (req.end_line > LAST_L)) ?
            req.start_line : req.end_line;
        add_first = (req.start_line > LAST_L) ? LAST_L : req.start_line;
        add_last  = (e > LAST_L) ? LAST_L : e;
    end

    assign req_ready = (state_reg == S_IDLE);

    // Sequencer: read, check and write back the entry RAM
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        enabled_next   = enabled_reg;
        cmp_next       = cmp_reg;
        fire_next      = fire_reg;
        fire_tag_next  = fire_tag_reg;
        rej_next       = rej_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // Retire the pending response
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next     = req;
                    fire_next     = 1'b0;
                    fire_tag_next = '0;
                    rej_next      = 1'b0;
                    state_next    = S_DONE;
                    unique case (req.action)
                        scs_pkg::ACT_ADD:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = IDX_W'(count_reg);
                                ram_wdata  = '{tag: req.entry_tag, first_line: add_first,
                                               last_line: add_last};
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        scs_pkg::ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        scs_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        scs_pkg::ACT_ENABLE:
                        begin
                            enabled_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                cur_next   = '0;
                                idx_next   = '0;
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_LOOKUP;
                            end
                        end
                        scs_pkg::ACT_DISABLE:
                        begin
                            enabled_next = 1'b0;
                            cmp_next     = '0;
                            cur_next     = '0;
                        end
                        scs_pkg::ACT_EVENT:
                        begin
                            if (enabled_reg && (count_reg != '0))
                            begin
                                idx_next   = cur_eff;
                                ram_re     = 1'b1;
                                ram_raddr  = cur_eff;
                                state_next = S_LOOKUP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Compare the tag of entry idx against the remove tag
            S_SEARCH:
            begin
                if (ram_rdata.tag == item_reg.entry_tag)
                begin
                    if (idx_p1 < (CNT_W+1)'(count_reg))
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = IDX_W'(idx_p1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 < (CNT_W+1)'(count_reg))
                begin
                    idx_next  = IDX_W'(idx_p1);
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(idx_p1);
                end
                else
                begin
                    rej_next   = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Move entry idx+1 down to idx
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = IDX_W'(idx_p1);
                if (idx_p2 < (CNT_W+1)'(count_reg))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(idx_p2);
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            // Evaluate the current entry for enable or a compare event
            S_LOOKUP:
            begin
                state_next = S_DONE;
                if (item_reg.action == scs_pkg::ACT_ENABLE)
                begin
                    cmp_next = ram_rdata.first_line;
                end
                else if (item_reg.line >= ram_rdata.first_line)
                begin
                    if (item_reg.line <= ram_rdata.last_line)
                    begin
                        fire_next     = 1'b1;
                        fire_tag_next = ram_rdata.tag;
                    end
                    if (item_reg.line < ram_rdata.last_line)
                    begin
                        cmp_next = item_reg.line + 8'd1;
                    end
                    else
                    begin
                        if (idx_p1 >= (CNT_W+1)'(count_reg))
                        begin
                            cur_next  = '0;
                            ram_raddr = '0;
                        end
                        else
                        begin
                            cur_next  = IDX_W'(idx_p1);
                            ram_raddr = IDX_W'(idx_p1);
                        end
                        ram_re     = 1'b1;
                        state_next = S_NEXT;
                    end
                end
            end

            // Take the start line of the next entry
            S_NEXT:
            begin
                cmp_next   = ram_rdata.first_line;
                state_next = S_DONE;
            end

            // Hand the response to the output register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = '{fire: fire_reg, fire_tag: fire_tag_reg,
                                 compare_line: cmp_reg,
                                 entry_count: 4'(count_reg), rejected: rej_reg};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            enabled_reg   <= 1'b0;
            cmp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            enabled_reg   <= enabled_next;
            cmp_reg       <= cmp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        fire_reg     <= fire_next;
        fire_tag_reg <= fire_tag_next;
        rej_reg      <= rej_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/scs_checker.sv */
// ----------------------------------------------------------------------------
// scs_checker
// Port-level assertions for the scanline callback scheduler, bound to the top.
// ----------------------------------------------------------------------------
module scs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input scs_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input scs_pkg::rsp_t rsp
);

    // Hold a stalled response transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Drop ready in the cycle after taking a request
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in back-to-back cycles");

    // Report a tag only when the entry fires
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.fire |-> rsp.fire_tag == 8'd0)
        else $error("tag shown without fire");

    // Never fire and reject in the same response
    a_fire_or_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.fire && rsp.rejected))
        else $error("fire and reject together");

    // Keep the entry count within the default table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= 4'(scs_pkg::MAX_ENTRIES_DEF))
        else $error("entry count above table depth");

endmodule

bind scanline_callback_scheduler scs_checker u_scs_checker (.*);
